/* hdl/rml_pkg.sv */
// Shared constants, types and reset values of the two-axis rate and magnitude limiter.
package rml_pkg;

   localparam int MAX_AXES      = 2;
   localparam int REGS_PER_AXIS = 4;
   localparam int NUM_REGS      = MAX_AXES * REGS_PER_AXIS;
   localparam int CSR_IDX_W     = $clog2(NUM_REGS);
   localparam int DATA_W        = 16;
   localparam int CHANGE_W      = DATA_W + 1;
   localparam int WIDE_W        = DATA_W + 2;
   localparam int REQ_TDATA_W   = ((MAX_AXES * DATA_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W   = MAX_AXES * (DATA_W + CHANGE_W);
   localparam int RSP_TDATA_W   = ((RSP_FIELD_W + 7) / 8) * 8;

   // Register offsets within one axis block.
   localparam int REG_LOWER_LIMIT = 0;
   localparam int REG_UPPER_LIMIT = 1;
   localparam int REG_DOWN_STEP   = 2;
   localparam int REG_UP_STEP     = 3;

   localparam logic [DATA_W-1:0] RESET_LOWER_LIMIT = 16'h8000;
   localparam logic [DATA_W-1:0] RESET_UPPER_LIMIT = 16'h7FFF;
   localparam logic [DATA_W-1:0] RESET_DOWN_STEP   = 16'h8000;
   localparam logic [DATA_W-1:0] RESET_UP_STEP     = 16'h7FFF;

   typedef struct packed {
      logic [DATA_W-1:0]   applied;
      logic [CHANGE_W-1:0] change;
   } lane_out_type;

   function automatic logic [DATA_W-1:0] reg_reset_value(input int idx);
      logic [DATA_W-1:0] value;
      value = RESET_LOWER_LIMIT;
      case (idx % REGS_PER_AXIS)
         REG_LOWER_LIMIT: value = RESET_LOWER_LIMIT;
         REG_UPPER_LIMIT: value = RESET_UPPER_LIMIT;
         REG_DOWN_STEP:   value = RESET_DOWN_STEP;
         REG_UP_STEP:     value = RESET_UP_STEP;
         default:         value = RESET_LOWER_LIMIT;
      endcase
      return value;
   endfunction

endpackage

/* hdl/rml_lane.sv */
// One axis lane: rate and magnitude clamp against the last applied value.
module rml_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [rml_pkg::DATA_W-1:0]        cmd,
   input  logic [rml_pkg::DATA_W-1:0]        lower_limit,
   input  logic [rml_pkg::DATA_W-1:0]        upper_limit,
   input  logic [rml_pkg::DATA_W-1:0]        down_step,
   input  logic [rml_pkg::DATA_W-1:0]        up_step,
   output rml_pkg::lane_out_type             result
);

   localparam int W  = rml_pkg::WIDE_W;
   localparam int DW = rml_pkg::DATA_W;
   localparam int EXT = W - DW;

   localparam logic signed [W-1:0] SAT_MAX = W'(signed'({1'b0, {(DW-1){1'b1}}}));
   localparam logic signed [W-1:0] SAT_MIN = -SAT_MAX - W'(1);

   logic [DW-1:0]        prev_ff;
   logic [DW-1:0]        prev_in;
   logic signed [W-1:0]  prev_x, cmd_x, lo_x, hi_x, dn_x, up_x;
   logic signed [W-1:0]  sum_up, sum_dn, ub, lb, u;
   logic signed [W-1:0]  diff;

   always_comb begin
      prev_x = signed'({{EXT{prev_ff[DW-1]}}, prev_ff});
      cmd_x  = signed'({{EXT{cmd[DW-1]}}, cmd});
      lo_x   = signed'({{EXT{lower_limit[DW-1]}}, lower_limit});
      hi_x   = signed'({{EXT{upper_limit[DW-1]}}, upper_limit});
      dn_x   = signed'({{EXT{down_step[DW-1]}}, down_step});
      up_x   = signed'({{EXT{up_step[DW-1]}}, up_step});

      sum_up = prev_x + up_x;
      sum_dn = prev_x + dn_x;
      ub = (sum_up < hi_x) ? sum_up : hi_x;
      lb = (sum_dn > lo_x) ? sum_dn : lo_x;

      // Upper bound first, lower bound wins when the two cross.
      u = cmd_x;
      if (u > ub) begin
         u = ub;
      end
      if (u < lb) begin
         u = lb;
      end
      if (u > SAT_MAX) begin
         u = SAT_MAX;
      end
      if (u < SAT_MIN) begin
         u = SAT_MIN;
      end

      diff           = u - prev_x;
      result.applied = u[DW-1:0];
      result.change  = diff[rml_pkg::CHANGE_W-1:0];
      prev_in        = accept ? u[DW-1:0] : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

/* hdl/rml_merge.sv */
// Merge lane results into one result transaction with an output register and a skid stage.
module rml_merge (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              accept,
   input  rml_pkg::lane_out_type [rml_pkg::MAX_AXES-1:0]     lanes,
   output logic                                              room,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   output logic [rml_pkg::RSP_TDATA_W-1:0]                   rsp_tdata
);

   localparam int DW = rml_pkg::DATA_W;
   localparam int CW = rml_pkg::CHANGE_W;
   localparam int NA = rml_pkg::MAX_AXES;

   logic [rml_pkg::RSP_TDATA_W-1:0] packed_w;
   logic [rml_pkg::RSP_TDATA_W-1:0] main_ff, main_in, skid_ff, skid_in;
   logic                            main_valid_ff, main_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic                            taken;

   always_comb begin
      packed_w = '0;
      for (int ax = 0; ax < NA; ax++) begin
         packed_w[ax*DW +: DW]         = lanes[ax].applied;
         packed_w[NA*DW + ax*CW +: CW] = lanes[ax].change;
      end
   end

   always_comb begin
      taken         = main_valid_ff & rsp_tready;
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (taken) begin
         // Advance the skid entry into the output register.
         main_in       = skid_ff;
         main_valid_in = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
      if (accept) begin
         if (!main_valid_ff || taken) begin
            main_in       = packed_w;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = packed_w;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign room       = ~skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff;

endmodule

/* hdl/two_axis_rate_magnitude_limiter.sv */
// Top level of the two-axis rate and magnitude limiter.
// Each result is registered in the output register, or in the skid stage while the rsp side stalls.
// Throughput: one transaction per cycle while req_tready is high; the lane feedback (last
//   applied value) closes through one register, and a one-entry skid stage keeps req_tready high
//   while one finished result waits on a stalled rsp side; req_tready drops once the skid is full.
// Reset: synchronous; clears the last applied values to zero, empties the output
//   stages and loads the limit and step registers with their widest settings.
module two_axis_rate_magnitude_limiter #(
   parameter int AXES = rml_pkg::MAX_AXES
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rml_pkg::REQ_TDATA_W-1:0]    req_tdata,   // cmd_a [15:0], cmd_b [31:16]
   // Result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rml_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // applied_a [15:0], applied_b [31:16],
                                                           // change_a [48:32], change_b [65:49],
                                                           // zero [71:66]
   // Register write port
   input  logic                               csr_wr_en,
   input  logic [rml_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rml_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int DW = rml_pkg::DATA_W;
   localparam int RA = rml_pkg::REGS_PER_AXIS;

   logic [DW-1:0]                                 cfg_ff [rml_pkg::NUM_REGS];
   logic                                          accept;
   logic                                          room;
   rml_pkg::lane_out_type [rml_pkg::MAX_AXES-1:0] lane_res;

   assign req_tready = room;
   assign accept     = req_tvalid & room;

   // Limit and step registers; every index of the port maps to a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < rml_pkg::NUM_REGS; r++) begin
            cfg_ff[r] <= rml_pkg::reg_reset_value(r);
         end
      end else if (csr_wr_en) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // One lane per active axis; an unused axis reports zeros.
   for (genvar ax = 0; ax < rml_pkg::MAX_AXES; ax++) begin : g_lane
      if (ax < AXES) begin : g_on
         rml_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .accept      (accept),
            .cmd         (req_tdata[ax*DW +: DW]),
            .lower_limit (cfg_ff[ax*RA + rml_pkg::REG_LOWER_LIMIT]),
            .upper_limit (cfg_ff[ax*RA + rml_pkg::REG_UPPER_LIMIT]),
            .down_step   (cfg_ff[ax*RA + rml_pkg::REG_DOWN_STEP]),
            .up_step     (cfg_ff[ax*RA + rml_pkg::REG_UP_STEP]),
            .result      (lane_res[ax])
         );
      end else begin : g_off
         assign lane_res[ax] = '0;
      end
   end

   // Combine lane results and hold them until the rsp side takes them.
   rml_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .lanes      (lane_res),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* tb/sv/two_axis_rate_magnitude_limiter_tb.sv */
// Self-checking testbench of the two-axis rate and magnitude limiter: random streams.
module two_axis_rate_magnitude_limiter_tb;
   import rml_pkg::*;

   // Build the block with both axes; the predictor follows the same setting.
   localparam int AXES = MAX_AXES;

   // Register block base of each axis.
   localparam int AXIS_A_BASE = 0;
   localparam int AXIS_B_BASE = REGS_PER_AXIS;

   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 119;
   localparam int LONG_HOLD     = 80;     // receiver hold-off, long enough to fill the block
   localparam int SETTLE_CYCLES = 4;      // margin after the last result before the next step
   localparam int IDLE_LIMIT    = 3000;   // cycles with no transaction before the run is abandoned

   localparam logic signed [WIDE_W-1:0] Q_MAX = 32767;
   localparam logic signed [WIDE_W-1:0] Q_MIN = -32768;

   // How the limit and step registers are chosen for a random phase.
   typedef enum int {
      CFG_REALISTIC,   // lower at or below upper, down step not positive, up step not negative
      CFG_WILD,        // any value, crossings and odd signs included
      CFG_EXTREME      // corner values only
   } cfg_style_type;

   typedef struct {
      logic signed [DATA_W-1:0]   applied_a;
      logic signed [DATA_W-1:0]   applied_b;
      logic signed [CHANGE_W-1:0] change_a;
      logic signed [CHANGE_W-1:0] change_b;
   } axis_outputs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // cmd_a [15:0], cmd_b [31:16]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // applied_a [15:0], applied_b [31:16],
                                               // change_a [48:32], change_b [65:49], zero [71:66]
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [DATA_W-1:0]      csr_wdata  = '0;

   // Predictor state: the limiter's registers and the last applied value of each axis.
   logic signed [DATA_W-1:0] limit_regs   [NUM_REGS];
   logic signed [DATA_W-1:0] last_applied [MAX_AXES];
   logic        [DATA_W-1:0] next_config  [NUM_REGS];

   logic [REQ_TDATA_W-1:0] pending_cmds [$];
   axis_outputs_type       expected_outputs [$];

   int queued_count   = 0;
   int accepted_count = 0;
   int result_count   = 0;
   int error_count    = 0;

   // Sender and receiver pacing.
   logic idle_enable   = 1'b1;
   logic req_accepted  = 1'b0;
   int   send_gap      = 0;
   int   stall_left    = 0;
   int   hold_left     = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;
   int   idle_cycles   = 0;

   string field_names [4] = '{"applied_a", "applied_b", "change_a", "change_b"};

   two_axis_rate_magnitude_limiter #(
      .AXES(AXES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH: %s", msg);
   endtask

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Corner values of a signed Q4.12 field.
   function automatic logic [DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return 16'h8001;
      endcase
   endfunction

   // Clamp each axis to its rate and magnitude bounds, then advance the stored values.
   function automatic axis_outputs_type predict_limited(input logic signed [DATA_W-1:0] cmd_a,
                                                        input logic signed [DATA_W-1:0] cmd_b);
      logic signed [DATA_W-1:0]   cmd     [MAX_AXES];
      logic signed [DATA_W-1:0]   applied [MAX_AXES];
      logic signed [CHANGE_W-1:0] change  [MAX_AXES];
      logic signed [WIDE_W-1:0]   rise;
      logic signed [WIDE_W-1:0]   fall;
      logic signed [WIDE_W-1:0]   ceiling;
      logic signed [WIDE_W-1:0]   bottom;
      logic signed [WIDE_W-1:0]   target;
      int                         base;
      axis_outputs_type           result;
      cmd[0] = cmd_a;
      cmd[1] = cmd_b;
      for (int ax = 0; ax < MAX_AXES; ax++) begin
         applied[ax] = '0;
         change[ax]  = '0;
         if (ax < AXES) begin
            base = ax * REGS_PER_AXIS;
            // Sums are wide enough that they never wrap.
            rise    = last_applied[ax] + limit_regs[base + REG_UP_STEP];
            fall    = last_applied[ax] + limit_regs[base + REG_DOWN_STEP];
            ceiling = limit_regs[base + REG_UPPER_LIMIT];
            bottom  = limit_regs[base + REG_LOWER_LIMIT];
            if (rise < ceiling) begin
               ceiling = rise;
            end
            if (fall > bottom) begin
               bottom = fall;
            end
            // Upper bound first, so the lower bound wins when they cross.
            target = cmd[ax];
            if (target > ceiling) begin
               target = ceiling;
            end
            if (target < bottom) begin
               target = bottom;
            end
            // The lower bound may lie above the 16-bit range: saturate.
            if (target > Q_MAX) begin
               target = Q_MAX;
            end
            if (target < Q_MIN) begin
               target = Q_MIN;
            end
            applied[ax]      = target[DATA_W-1:0];
            change[ax]       = applied[ax] - last_applied[ax];
            last_applied[ax] = applied[ax];
         end
      end
      result.applied_a = applied[0];
      result.applied_b = applied[1];
      result.change_a  = change[0];
      result.change_b  = change[1];
      return result;
   endfunction

   // Queue one command pair for the sender.
   task automatic queue_command(input logic [DATA_W-1:0] cmd_a, input logic [DATA_W-1:0] cmd_b);
      logic [REQ_TDATA_W-1:0] packed_cmd;
      packed_cmd = '0;
      packed_cmd[0 +: DATA_W]      = cmd_a;
      packed_cmd[DATA_W +: DATA_W] = cmd_b;
      pending_cmds.push_back(packed_cmd);
      queued_count++;
   endtask

   // Write every register from next_config; only called while the block is idle.
   task automatic apply_config();
      for (int i = 0; i < NUM_REGS; i++) begin
         @(negedge clock);
         csr_wr_en     <= 1'b1;
         csr_index     <= CSR_IDX_W'(i);
         csr_wdata     <= next_config[i];
         limit_regs[i]  = next_config[i];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold the stimulus until every queued command has been taken and every result checked,
   // then let the pipeline settle.
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_outputs.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: hold a transaction until taken, then advance after a random gap.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_accepted) begin
         // hold: the offered transaction has not been taken yet
      end else if (send_gap > 0) begin
         send_gap   <= send_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
         req_tdata  <= pending_cmds.pop_front();
         req_tvalid <= 1'b1;
         send_gap   <= pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result receiver: a long hold-off on request, always ready while idle gaps are off, otherwise random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD - 1;
         rsp_tready  <= 1'b0;
      end else if (!idle_enable) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: check the result transaction against the oldest prediction, then predict
   // for the request transaction taken at this edge.
   always @(posedge clock) begin
      axis_outputs_type           want;
      logic signed [CHANGE_W-1:0] got_f  [4];
      logic signed [CHANGE_W-1:0] want_f [4];
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch($sformatf("result transaction %0d arrived with none expected",
                                         result_count));
            end else begin
               want      = expected_outputs.pop_front();
               got_f[0]  = $signed(rsp_tdata[0 +: DATA_W]);
               got_f[1]  = $signed(rsp_tdata[DATA_W +: DATA_W]);
               got_f[2]  = $signed(rsp_tdata[2*DATA_W +: CHANGE_W]);
               got_f[3]  = $signed(rsp_tdata[2*DATA_W+CHANGE_W +: CHANGE_W]);
               want_f[0] = want.applied_a;
               want_f[1] = want.applied_b;
               want_f[2] = want.change_a;
               want_f[3] = want.change_b;
               for (int f = 0; f < 4; f++) begin
                  if (got_f[f] !== want_f[f]) begin
                     report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                               result_count, field_names[f], got_f[f],
                                               want_f[f]));
                  end
               end
            end
            result_count++;
         end
         if (req_tvalid && req_tready) begin
            expected_outputs.push_back(predict_limited(req_tdata[0 +: DATA_W],
                                                       req_tdata[DATA_W +: DATA_W]));
            accepted_count++;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus sequence.
   initial begin
      logic [DATA_W-1:0] cmd   [MAX_AXES];
      logic [DATA_W-1:0] recent [MAX_AXES];
      cfg_style_type     style;
      int                base;

      // Predictor starts from the reset state of the block.
      for (int ax = 0; ax < MAX_AXES; ax++) begin
         base = ax * REGS_PER_AXIS;
         limit_regs[base + REG_LOWER_LIMIT] = RESET_LOWER_LIMIT;
         limit_regs[base + REG_UPPER_LIMIT] = RESET_UPPER_LIMIT;
         limit_regs[base + REG_DOWN_STEP]   = RESET_DOWN_STEP;
         limit_regs[base + REG_UP_STEP]     = RESET_UP_STEP;
         last_applied[ax] = '0;
         recent[ax]       = '0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: full-scale swings, the largest changes in both directions.
      @(posedge clock);
      queue_command(16'h7FFF, 16'h8000);
      queue_command(16'h7FFF, 16'h8000);
      queue_command(16'h8000, 16'h7FFF);
      queue_command(16'h8000, 16'h7FFF);
      queue_command(16'h8000, 16'h7FFF);
      queue_command(16'h0000, 16'hFFFF);
      queue_command(16'hFFFF, 16'h0001);
      queue_command(16'h5555, 16'hAAAA);
      wait_drained();

      // Axis A: ordinary limits and steps. Axis B: lower limit above upper limit.
      next_config[AXIS_A_BASE + REG_LOWER_LIMIT] = 16'(-4096);
      next_config[AXIS_A_BASE + REG_UPPER_LIMIT] = 16'(4096);
      next_config[AXIS_A_BASE + REG_DOWN_STEP]   = 16'(-512);
      next_config[AXIS_A_BASE + REG_UP_STEP]     = 16'(512);
      next_config[AXIS_B_BASE + REG_LOWER_LIMIT] = 16'(2000);
      next_config[AXIS_B_BASE + REG_UPPER_LIMIT] = 16'(-2000);
      next_config[AXIS_B_BASE + REG_DOWN_STEP]   = 16'h8000;
      next_config[AXIS_B_BASE + REG_UP_STEP]     = 16'h7FFF;
      apply_config();
      @(posedge clock);
      queue_command(16'h7FFF, 16'h7FFF);
      queue_command(16'h7FFF, 16'h8000);
      queue_command(16'h8000, 16'h0000);
      queue_command(16'h8000, 16'h7FFF);
      queue_command(16'h1000, 16'hF000);
      queue_command(16'h0000, 16'h0000);
      wait_drained();

      // Axis A: positive down step pushes the lower bound past full scale (saturates).
      // Axis B: single-LSB rate limits against full-scale commands.
      next_config[AXIS_A_BASE + REG_LOWER_LIMIT] = 16'h8000;
      next_config[AXIS_A_BASE + REG_UPPER_LIMIT] = 16'h7FFF;
      next_config[AXIS_A_BASE + REG_DOWN_STEP]   = 16'h7FFF;
      next_config[AXIS_A_BASE + REG_UP_STEP]     = 16'h7FFF;
      next_config[AXIS_B_BASE + REG_LOWER_LIMIT] = 16'h8000;
      next_config[AXIS_B_BASE + REG_UPPER_LIMIT] = 16'h7FFF;
      next_config[AXIS_B_BASE + REG_DOWN_STEP]   = 16'(-1);
      next_config[AXIS_B_BASE + REG_UP_STEP]     = 16'(1);
      apply_config();
      @(posedge clock);
      queue_command(16'h0100, 16'h7FFF);
      queue_command(16'h8000, 16'h7FFF);
      queue_command(16'h7FFF, 16'h8000);
      queue_command(16'h0000, 16'h8000);
      queue_command(16'h8000, 16'h8000);
      queue_command(16'h4000, 16'h0000);
      queue_command(16'h7FFF, 16'h7FFF);
      queue_command(16'hC000, 16'hC000);
      wait_drained();

      // Random phases: a fresh register set each time, random commands with a bias toward
      // small moves so the rate limits engage.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = cfg_style_type'(phase % 3);
         for (int ax = 0; ax < MAX_AXES; ax++) begin
            base = ax * REGS_PER_AXIS;
            case (style)
               CFG_REALISTIC: begin
                  next_config[base + REG_LOWER_LIMIT] = 16'(-int'($urandom_range(0, 32768)));
                  next_config[base + REG_UPPER_LIMIT] = 16'($urandom_range(0, 32767));
                  next_config[base + REG_DOWN_STEP]   = 16'(-int'($urandom_range(0, 6000)));
                  next_config[base + REG_UP_STEP]     = 16'($urandom_range(0, 6000));
               end
               CFG_WILD: begin
                  for (int r = 0; r < REGS_PER_AXIS; r++) begin
                     next_config[base + r] = $urandom_range(0, 1) ?
                                             16'($urandom_range(0, 65535)) : pick_extreme();
                  end
               end
               default: begin
                  for (int r = 0; r < REGS_PER_AXIS; r++) begin
                     next_config[base + r] = pick_extreme();
                  end
               end
            endcase
         end
         apply_config();

         // Drop the idle gaps on some phases; ask for a long receiver hold-off on others.
         @(posedge clock);
         idle_enable = (phase % 4 != 1);
         if (phase == 2 || phase == 7) begin
            hold_requests++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            for (int ax = 0; ax < MAX_AXES; ax++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: cmd[ax] = 16'($urandom_range(0, 65535));
                  4, 5:       cmd[ax] = pick_extreme();
                  default:    cmd[ax] = 16'(int'($signed(recent[ax])) +
                                            int'($urandom_range(0, 4096)) - 2048);
               endcase
               recent[ax] = cmd[ax];
            end
            queue_command(cmd[0], cmd[1]);
         end
         wait_drained();
      end

      idle_enable = 1'b1;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_outputs.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived", expected_outputs.size()));
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
